// ===== sv/cfa_pkg.sv =====
`default_nettype none
package cfa_pkg;
	localparam int MAX_SEGMENTS = 32;
	localparam int ADDR_BITS = 20;
	localparam int IDX_W = $clog2(MAX_SEGMENTS);
	localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
	localparam int SIZE_W = 21;
	localparam int OWNER_W = 16;
	localparam int BASE_W = 20;
	localparam logic [SIZE_W-1:0] SIZE_LIMIT = SIZE_W'(1) << ADDR_BITS;

	typedef enum logic [1:0] {
		REQ_ALLOC = 2'd0,
		REQ_FREE = 2'd1,
		REQ_COMPACT = 2'd2,
		REQ_STATUS = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		RC_OK = 2'd0,
		RC_NO_HOLE = 2'd1,
		RC_NO_OWNER = 2'd2,
		RC_FULL = 2'd3
	} rc_t;

	typedef enum logic [1:0] {
		FIT_FIRST = 2'd0,
		FIT_BEST = 2'd1,
		FIT_WORST = 2'd2,
		FIT_ALT = 2'd3
	} fit_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_GRANT,
		ST_FREE,
		ST_COMPACT,
		ST_CHOLE,
		ST_LIST,
		ST_OUT
	} state_t;

	typedef struct packed {
		rc_t code;
		logic [BASE_W-1:0] base;
		logic [SIZE_W-1:0] size;
		logic [OWNER_W-1:0] holder;
		logic busy;
		logic [SIZE_W-1:0] free;
		logic last;
	} result_t;
endpackage
`default_nettype wire

// ===== sv/cfa_out_reg.sv =====
`default_nettype none
// One-entry output register between the sequencer and the result channel.
module cfa_out_reg (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic load,
	input wire cfa_pkg::result_t din,
	output logic full,
	output cfa_pkg::result_t dout,
	input wire logic take
);
	logic full_q;
	cfa_pkg::result_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (load) begin
			full_q <= 1'b1;
		end else if (take) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= din;
		end
	end

	assign full = full_q;
	assign dout = data_q;
endmodule
`default_nettype wire

// ===== sv/contiguous_fit_allocator_top.sv =====
`default_nettype none
// Contiguous memory allocator with first, best and worst fit placement.
// Input beats on s_axis carry an operation: request, release, compact or a
// status listing. Each operation gives one result beat on m_axis, except a
// status listing, which gives one beat per segment (busy ones first, then
// holes) with tlast on the final one. tlast marks the last beat of every
// operation. The cfg channel writes memory_size and reinitializes the table
// to a single free segment; write it only while the block is idle.
// The block works on one operation at a time and s_axis_tready is low until
// the last result beat has been taken. The sequencer walks the segment table
// one entry per cycle, except that a listing pauses while the output register
// holds a beat. A request scans up to 32 entries, then on a split moves the
// tail up one entry per cycle before it grants the chosen hole. A release
// scans up to 32 entries; a compact walks every entry once and then places
// the end hole, if any. A listing walks the table twice, busy entries first,
// and after every emitted beat waits for the output register to drain.
// Reset sets memory_size to 2^20 and holds one free segment of that size.
// When the receiver stalls, the sequencer waits with the result in the
// output register and resumes once it is taken.
module contiguous_fit_allocator_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// [1:0] req_type, [17:2] owner_id, [38:18] request_size, [40:39] fit_mode
	input wire logic [47:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	// [1:0] result_code, [21:2] seg_base, [42:22] seg_size, [58:43] seg_holder,
	// [59] seg_busy, [80:60] free_units
	output logic [87:0] m_axis_tdata,
	output logic m_axis_tlast,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [20:0] cfg_data
);
	localparam int IW = cfa_pkg::IDX_W;
	localparam int CW = cfa_pkg::CNT_W;
	localparam int SW = cfa_pkg::SIZE_W;
	localparam int BW = cfa_pkg::BASE_W;
	localparam int OW = cfa_pkg::OWNER_W;
	localparam int N = cfa_pkg::MAX_SEGMENTS;

	// Segment table kept in flip-flops; it is indexed by the scan index i_q, the
	// picked entry pick_q and the compaction write index w_q; the shift step moves entry i-1 to i.
	logic [OW-1:0] own_q [N];
	logic [N-1:0] busy_q;
	logic [BW-1:0] base_q [N];
	logic [SW-1:0] size_q [N];
	logic [CW-1:0] cnt_q;
	logic [SW-1:0] freet_q;

	cfa_pkg::state_t state_q, state_d;
	logic [OW-1:0] ownr_q;
	logic [SW-1:0] req_q;
	logic [1:0] mode_q;
	logic [CW-1:0] i_q;
	logic [IW-1:0] pick_q;
	logic found_q;
	logic pass_q;
	logic [CW-1:0] k_q;
	logic [CW-1:0] w_q;
	logic [SW-1:0] addr_q;
	logic [SW-1:0] memsz_q;

	logic ob_full, ob_load, ob_take;
	cfa_pkg::result_t ob_din, ob_dout;

	logic [IW-1:0] ix;
	logic [SW-1:0] cur_size;
	logic cur_busy;
	logic adequate, better;
	logic [SW-1:0] left;
	logic [SW-1:0] cfg_v;
	logic [CW-1:0] n_eff;
	logic scan_done;

	assign ix = i_q[IW-1:0];
	assign cur_size = size_q[ix];
	assign cur_busy = busy_q[ix];
	assign n_eff = cnt_q;
	assign left = size_q[pick_q] - req_q;
	assign adequate = !cur_busy && (req_q != '0) && (cur_size >= req_q);
	// First fit (and the unused fourth mode) stops at the first adequate hole.
	assign scan_done = (i_q >= n_eff) || (found_q && mode_q != cfa_pkg::FIT_BEST
		&& mode_q != cfa_pkg::FIT_WORST);
	always_comb begin
		unique case (cfa_pkg::fit_t'(mode_q))
			cfa_pkg::FIT_BEST: better = !found_q || (cur_size < size_q[pick_q]);
			cfa_pkg::FIT_WORST: better = !found_q || (cur_size > size_q[pick_q]);
			default: better = 1'b1;
		endcase
	end

	always_comb begin
		if (cfg_data == '0) begin
			cfg_v = SW'(1);
		end else if (cfg_data > cfa_pkg::SIZE_LIMIT) begin
			cfg_v = cfa_pkg::SIZE_LIMIT;
		end else begin
			cfg_v = cfg_data;
		end
	end

	assign cfg_ready = (state_q == cfa_pkg::ST_IDLE) && !ob_full;
	assign s_axis_tready = (state_q == cfa_pkg::ST_IDLE) && !ob_full && !cfg_valid;
	assign ob_take = ob_full && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	logic list_emit;
	logic [CW-1:0] total;
	assign total = n_eff;
	assign list_emit = (i_q < n_eff) && (cur_busy == !pass_q);

	// Sequencer: next state and the result beat to load.
	always_comb begin
		state_d = state_q;
		ob_load = 1'b0;
		ob_din = '0;
		ob_din.free = freet_q;
		ob_din.holder = ownr_q;
		ob_din.last = 1'b1;
		unique case (state_q)
			cfa_pkg::ST_IDLE: begin
				if (s_axis_tvalid && s_axis_tready) begin
					unique case (cfa_pkg::req_t'(s_axis_tdata[1:0]))
						cfa_pkg::REQ_ALLOC: state_d = cfa_pkg::ST_SCAN;
						cfa_pkg::REQ_FREE: state_d = cfa_pkg::ST_FREE;
						cfa_pkg::REQ_COMPACT: state_d = cfa_pkg::ST_COMPACT;
						cfa_pkg::REQ_STATUS: state_d = cfa_pkg::ST_LIST;
					endcase
				end
			end
			cfa_pkg::ST_SCAN: begin
				if (scan_done) begin
					if (!found_q) begin
						ob_din.code = cfa_pkg::RC_NO_HOLE;
						ob_load = 1'b1;
						state_d = cfa_pkg::ST_OUT;
					end else if (left != '0 && n_eff >= CW'(N)) begin
						ob_din.code = cfa_pkg::RC_FULL;
						ob_load = 1'b1;
						state_d = cfa_pkg::ST_OUT;
					end else if (left != '0) begin
						state_d = cfa_pkg::ST_SHIFT;
					end else begin
						state_d = cfa_pkg::ST_GRANT;
					end
				end
			end
			cfa_pkg::ST_SHIFT: begin
				if (i_q <= CW'(pick_q) + CW'(1)) begin
					state_d = cfa_pkg::ST_GRANT;
				end
			end
			cfa_pkg::ST_GRANT: begin
				ob_din.code = cfa_pkg::RC_OK;
				ob_din.base = base_q[pick_q];
				ob_din.size = req_q;
				ob_din.busy = 1'b1;
				ob_din.free = freet_q - req_q;
				ob_load = 1'b1;
				state_d = cfa_pkg::ST_OUT;
			end
			cfa_pkg::ST_FREE: begin
				if (i_q >= n_eff) begin
					ob_din.code = cfa_pkg::RC_NO_OWNER;
					ob_load = 1'b1;
					state_d = cfa_pkg::ST_OUT;
				end else if (cur_busy && own_q[ix] == ownr_q) begin
					ob_din.code = cfa_pkg::RC_OK;
					ob_din.base = base_q[ix];
					ob_din.size = cur_size;
					ob_din.free = freet_q + cur_size;
					ob_load = 1'b1;
					state_d = cfa_pkg::ST_OUT;
				end
			end
			cfa_pkg::ST_COMPACT: begin
				if (i_q >= n_eff) begin
					state_d = cfa_pkg::ST_CHOLE;
				end
			end
			cfa_pkg::ST_CHOLE: begin
				ob_din.code = cfa_pkg::RC_OK;
				ob_din.holder = '0;
				if (freet_q != '0 && w_q < CW'(N)) begin
					ob_din.base = addr_q[BW-1:0];
					ob_din.size = freet_q;
				end
				ob_load = 1'b1;
				state_d = cfa_pkg::ST_OUT;
			end
			cfa_pkg::ST_LIST: begin
				if (!ob_full) begin
					if (i_q >= n_eff) begin
						if (pass_q) begin
							state_d = cfa_pkg::ST_IDLE;
						end
					end else if (list_emit) begin
						ob_din.code = cfa_pkg::RC_OK;
						ob_din.base = base_q[ix];
						ob_din.size = cur_size;
						ob_din.holder = cur_busy ? own_q[ix] : '0;
						ob_din.busy = cur_busy;
						ob_din.last = (k_q == total - CW'(1));
						ob_load = 1'b1;
					end
				end
			end
			cfa_pkg::ST_OUT: state_d = cfa_pkg::ST_IDLE;
			default: state_d = cfa_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
			cnt_q <= CW'(1);
			freet_q <= cfa_pkg::SIZE_LIMIT;
			memsz_q <= cfa_pkg::SIZE_LIMIT;
			base_q[0] <= '0;
			size_q[0] <= cfa_pkg::SIZE_LIMIT;
			for (int j = 1; j < N; j++) begin
				base_q[j] <= '0;
				size_q[j] <= '0;
			end
			i_q <= '0;
			found_q <= 1'b0;
			pass_q <= 1'b0;
			k_q <= '0;
			w_q <= '0;
			addr_q <= '0;
		end else begin
			unique case (state_q)
				cfa_pkg::ST_IDLE: begin
					i_q <= '0;
					found_q <= 1'b0;
					pass_q <= 1'b0;
					k_q <= '0;
					w_q <= '0;
					addr_q <= '0;
					if (cfg_valid && cfg_ready) begin
						memsz_q <= cfg_v;
						busy_q <= '0;
						cnt_q <= CW'(1);
						freet_q <= cfg_v;
						base_q[0] <= '0;
						size_q[0] <= cfg_v;
					end
				end
				cfa_pkg::ST_SCAN: begin
					if (scan_done) begin
						i_q <= n_eff;
					end else begin
						if (adequate && better) begin
							pick_q <= ix;
							found_q <= 1'b1;
						end
						i_q <= i_q + CW'(1);
					end
				end
				cfa_pkg::ST_SHIFT: begin
					if (i_q > CW'(pick_q) + CW'(1)) begin
						own_q[ix] <= own_q[ix - IW'(1)];
						busy_q[ix] <= busy_q[ix - IW'(1)];
						base_q[ix] <= base_q[ix - IW'(1)];
						size_q[ix] <= size_q[ix - IW'(1)];
						i_q <= i_q - CW'(1);
					end else begin
						own_q[ix] <= '0;
						busy_q[ix] <= 1'b0;
						base_q[ix] <= base_q[pick_q] + req_q[BW-1:0];
						size_q[ix] <= left;
						cnt_q <= cnt_q + CW'(1);
					end
				end
				cfa_pkg::ST_GRANT: begin
					busy_q[pick_q] <= 1'b1;
					own_q[pick_q] <= ownr_q;
					size_q[pick_q] <= req_q;
					freet_q <= freet_q - req_q;
				end
				cfa_pkg::ST_FREE: begin
					if (i_q < n_eff) begin
						if (cur_busy && own_q[ix] == ownr_q) begin
							busy_q[ix] <= 1'b0;
							freet_q <= freet_q + cur_size;
						end
						i_q <= i_q + CW'(1);
					end
				end
				cfa_pkg::ST_COMPACT: begin
					if (i_q < n_eff) begin
						if (cur_busy) begin
							own_q[w_q[IW-1:0]] <= own_q[ix];
							busy_q[w_q[IW-1:0]] <= 1'b1;
							base_q[w_q[IW-1:0]] <= addr_q[BW-1:0];
							size_q[w_q[IW-1:0]] <= cur_size;
							addr_q <= addr_q + cur_size;
							w_q <= w_q + CW'(1);
						end
						i_q <= i_q + CW'(1);
					end
				end
				cfa_pkg::ST_CHOLE: begin
					if (freet_q != '0 && w_q < CW'(N)) begin
						own_q[w_q[IW-1:0]] <= '0;
						busy_q[w_q[IW-1:0]] <= 1'b0;
						base_q[w_q[IW-1:0]] <= addr_q[BW-1:0];
						size_q[w_q[IW-1:0]] <= freet_q;
						cnt_q <= w_q + CW'(1);
					end else begin
						cnt_q <= w_q;
					end
				end
				cfa_pkg::ST_LIST: begin
					if (!ob_full) begin
						if (i_q >= n_eff) begin
							pass_q <= 1'b1;
							i_q <= '0;
						end else begin
							if (list_emit) begin
								k_q <= k_q + CW'(1);
							end
							i_q <= i_q + CW'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			ownr_q <= s_axis_tdata[17:2];
			req_q <= s_axis_tdata[38:18];
			mode_q <= s_axis_tdata[40:39];
		end
	end

	cfa_out_reg u_out (
		.clk(clk),
		.arst_n(arst_n),
		.load(ob_load),
		.din(ob_din),
		.full(ob_full),
		.dout(ob_dout),
		.take(ob_take)
	);

	assign m_axis_tvalid = ob_full;
	assign m_axis_tlast = ob_dout.last;
	assign m_axis_tdata = {7'd0, ob_dout.free, ob_dout.busy, ob_dout.holder,
		ob_dout.size, ob_dout.base, ob_dout.code};

	// Free units never exceed the configured memory size.
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		freet_q <= memsz_q) else $error("free total above memory size");
	// Outside the idle, end-hole and closing states the segment count stays within the table.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(N) && cnt_q != '0 || state_q == cfa_pkg::ST_CHOLE
		|| state_q == cfa_pkg::ST_OUT || state_q == cfa_pkg::ST_IDLE)
		else $error("segment count out of range");
	// No input is taken while a result is pending.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ob_full |-> !s_axis_tready) else $error("accept while result pending");
	// A single-result operation moves to the closing state after its beat.
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		(ob_load && state_q != cfa_pkg::ST_LIST) |=> state_q == cfa_pkg::ST_OUT)
		else $error("single-result op did not finish");
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	localparam int OWNER_W = cfa_pkg::OWNER_W;
	localparam int BASE_W = cfa_pkg::BASE_W;
	localparam int SIZE_W = cfa_pkg::SIZE_W;
	localparam int MAX_SEGMENTS = cfa_pkg::MAX_SEGMENTS;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	// [1:0] req_type, [17:2] owner_id, [38:18] request_size, [40:39] fit_mode
	logic [47:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// [1:0] result_code, [21:2] seg_base, [42:22] seg_size, [58:43] seg_holder,
	// [59] seg_busy, [80:60] free_units
	logic [87:0] m_axis_tdata;
	logic m_axis_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [20:0] cfg_data = '0;

	contiguous_fit_allocator_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// The clock runs with a 12 ns period.
	always #6 clk = ~clk;

	// Shadow copy of the segment table, updated as each operation is accepted.
	logic [OWNER_W-1:0] sh_owner [MAX_SEGMENTS];
	logic sh_busy [MAX_SEGMENTS];
	logic [BASE_W-1:0] sh_base [MAX_SEGMENTS];
	logic [SIZE_W-1:0] sh_size [MAX_SEGMENTS];
	int sh_count;
	logic [SIZE_W-1:0] sh_free;
	logic [SIZE_W-1:0] sh_mem;

	// Result beats that the table predicts and that have not arrived yet.
	cfa_pkg::result_t pending_beats[$];

	int errors = 0;
	int ops_sent = 0;
	int beats_seen = 0;
	int configs_done = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;
	logic [OWNER_W-1:0] owner_pool [8];

	function automatic cfa_pkg::result_t mk_beat(cfa_pkg::rc_t code,
		logic [BASE_W-1:0] base, logic [SIZE_W-1:0] size, logic [OWNER_W-1:0] holder,
		logic busy, logic last);
		cfa_pkg::result_t r;
		r.code = code;
		r.base = base;
		r.size = size;
		r.holder = holder;
		r.busy = busy;
		r.free = sh_free;
		r.last = last;
		return r;
	endfunction

	task automatic table_reinit();
		for (int i = 0; i < MAX_SEGMENTS; i++) begin
			sh_owner[i] = '0;
			sh_busy[i] = 1'b0;
			sh_base[i] = '0;
			sh_size[i] = '0;
		end
		sh_size[0] = sh_mem;
		sh_count = 1;
		sh_free = sh_mem;
	endtask

	// Works out the result beats of one operation and updates the shadow table.
	task automatic predict_op(cfa_pkg::req_t kind, logic [OWNER_W-1:0] owner,
		logic [SIZE_W-1:0] req, cfa_pkg::fit_t mode);
		int pick;
		int w;
		int k;
		logic [SIZE_W-1:0] left;
		logic [BASE_W-1:0] addr;
		pick = -1;
		w = 0;
		k = 0;
		addr = '0;
		case (kind)
			cfa_pkg::REQ_ALLOC: begin
				for (int i = 0; i < sh_count; i++) begin
					if (sh_busy[i] || req == 0 || sh_size[i] < req) continue;
					if (mode == cfa_pkg::FIT_BEST) begin
						if (pick < 0 || sh_size[i] < sh_size[pick]) pick = i;
					end else if (mode == cfa_pkg::FIT_WORST) begin
						if (pick < 0 || sh_size[i] > sh_size[pick]) pick = i;
					end else begin
						pick = i;
						break;
					end
				end
				if (pick < 0) begin
					pending_beats.push_back(mk_beat(cfa_pkg::RC_NO_HOLE, '0, '0, owner,
						1'b0, 1'b1));
				end else begin
					left = sh_size[pick] - req;
					if (left != 0 && sh_count >= MAX_SEGMENTS) begin
						pending_beats.push_back(mk_beat(cfa_pkg::RC_FULL, '0, '0, owner,
							1'b0, 1'b1));
					end else begin
						if (left != 0) begin
							for (int i = sh_count; i > pick + 1; i--) begin
								sh_owner[i] = sh_owner[i-1];
								sh_busy[i] = sh_busy[i-1];
								sh_base[i] = sh_base[i-1];
								sh_size[i] = sh_size[i-1];
							end
							sh_owner[pick+1] = '0;
							sh_busy[pick+1] = 1'b0;
							sh_base[pick+1] = sh_base[pick] + BASE_W'(req);
							sh_size[pick+1] = left;
							sh_count++;
						end
						sh_busy[pick] = 1'b1;
						sh_owner[pick] = owner;
						sh_size[pick] = req;
						sh_free = sh_free - req;
						pending_beats.push_back(mk_beat(cfa_pkg::RC_OK, sh_base[pick], req,
							owner, 1'b1, 1'b1));
					end
				end
			end
			cfa_pkg::REQ_FREE: begin
				for (int i = 0; i < sh_count; i++) begin
					if (sh_busy[i] && sh_owner[i] == owner) begin
						pick = i;
						break;
					end
				end
				if (pick < 0) begin
					pending_beats.push_back(mk_beat(cfa_pkg::RC_NO_OWNER, '0, '0, owner,
						1'b0, 1'b1));
				end else begin
					sh_busy[pick] = 1'b0;
					sh_free = sh_free + sh_size[pick];
					pending_beats.push_back(mk_beat(cfa_pkg::RC_OK, sh_base[pick],
						sh_size[pick], owner, 1'b0, 1'b1));
				end
			end
			cfa_pkg::REQ_COMPACT: begin
				for (int i = 0; i < sh_count; i++) begin
					if (!sh_busy[i]) continue;
					sh_owner[w] = sh_owner[i];
					sh_busy[w] = 1'b1;
					sh_base[w] = addr;
					sh_size[w] = sh_size[i];
					addr = addr + BASE_W'(sh_size[i]);
					w++;
				end
				if (sh_free != 0 && w < MAX_SEGMENTS) begin
					sh_owner[w] = '0;
					sh_busy[w] = 1'b0;
					sh_base[w] = addr;
					sh_size[w] = sh_free;
					w++;
					sh_count = w;
					pending_beats.push_back(mk_beat(cfa_pkg::RC_OK, addr, sh_free, '0,
						1'b0, 1'b1));
				end else begin
					sh_count = w;
					pending_beats.push_back(mk_beat(cfa_pkg::RC_OK, '0, '0, '0,
						1'b0, 1'b1));
				end
			end
			default: begin
				// Busy segments are listed first, then holes, each in address order.
				for (int p = 0; p < 2; p++) begin
					for (int i = 0; i < sh_count; i++) begin
						if (sh_busy[i] != (p == 0)) continue;
						pending_beats.push_back(mk_beat(cfa_pkg::RC_OK, sh_base[i],
							sh_size[i], (p == 0) ? sh_owner[i] : '0, sh_busy[i],
							k == sh_count - 1));
						k++;
					end
				end
			end
		endcase
	endtask

	// Sends one operation beat; the sender may idle first, as the phase dictates.
	task automatic send_op(cfa_pkg::req_t kind, logic [OWNER_W-1:0] owner,
		logic [SIZE_W-1:0] req, cfa_pkg::fit_t mode);
		@(negedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'd0, mode, req, owner, kind};
		do @(posedge clk); while (!s_axis_tready);
		predict_op(kind, owner, req, mode);
		ops_sent++;
	endtask

	// Lowers tvalid and waits until every predicted beat has arrived, then
	// lets the block settle for roughly one worst-case operation.
	task automatic drain();
		int guard;
		guard = 0;
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_beats.size() != 0 && guard < 400000) begin
			@(posedge clk);
			guard++;
		end
		if (guard >= 400000) begin
			$display("%0t: timeout waiting for %0d result beats", $time,
				pending_beats.size());
			$display("Simulation FAILED");
			$finish;
		end else begin
			repeat (100) @(posedge clk);
		end
	endtask

	// Writes memory_size; the block must be idle. The value is clamped to the
	// legal range the same way the block does.
	task automatic write_mem_size(logic [20:0] value);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (value == 0) sh_mem = 1;
		else if (value > cfa_pkg::SIZE_LIMIT) sh_mem = cfa_pkg::SIZE_LIMIT;
		else sh_mem = value;
		table_reinit();
		configs_done++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// The receiver stalls at random, and for the whole of a forced hold-off.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_axis_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Each result beat is checked against the oldest prediction.
	always @(posedge clk) begin
		cfa_pkg::result_t got;
		cfa_pkg::result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.code = cfa_pkg::rc_t'(m_axis_tdata[1:0]);
			got.base = m_axis_tdata[21:2];
			got.size = m_axis_tdata[42:22];
			got.holder = m_axis_tdata[58:43];
			got.busy = m_axis_tdata[59];
			got.free = m_axis_tdata[80:60];
			got.last = m_axis_tlast;
			beats_seen++;
			if (pending_beats.size() == 0) begin
				$display("%0t: unexpected beat code=%0d base=%0d size=%0d holder=%h",
					$time, got.code, got.base, got.size, got.holder);
				errors++;
			end else begin
				want = pending_beats.pop_front();
				if (got !== want) begin
					$display("%0t: mismatch expected code=%0d base=%0d size=%0d holder=%h busy=%0d free=%0d last=%0d",
						$time, want.code, want.base, want.size, want.holder, want.busy,
						want.free, want.last);
					$display("%0t:          actual code=%0d base=%0d size=%0d holder=%h busy=%0d free=%0d last=%0d",
						$time, got.code, got.base, got.size, got.holder, got.busy,
						got.free, got.last);
					errors++;
				end
			end
		end
	end

	// After reset the table must hold one hole covering the full 2^20 units.
	task automatic test_reset_state();
		send_op(cfa_pkg::REQ_STATUS, 16'h0000, '0, cfa_pkg::FIT_FIRST);
		send_op(cfa_pkg::REQ_FREE, 16'hFFFF, '0, cfa_pkg::FIT_FIRST);
		send_op(cfa_pkg::REQ_COMPACT, 16'h0000, '0, cfa_pkg::FIT_FIRST);
	endtask

	// Field extremes, every fit mode, zero and oversize requests, a release of
	// an unknown owner, and compaction of fragmented holes.
	task automatic test_directed_ops();
		send_op(cfa_pkg::REQ_ALLOC, 16'h0001, 21'd0, cfa_pkg::FIT_FIRST);
		send_op(cfa_pkg::REQ_ALLOC, 16'h0002, 21'h1FFFFF, cfa_pkg::FIT_WORST);
		send_op(cfa_pkg::REQ_ALLOC, 16'hFFFF, 21'd100, cfa_pkg::FIT_FIRST);
		send_op(cfa_pkg::REQ_ALLOC, 16'h0003, 21'd5, cfa_pkg::FIT_BEST);
		send_op(cfa_pkg::REQ_ALLOC, 16'h5A5A, 21'd300, cfa_pkg::FIT_ALT);
		send_op(cfa_pkg::REQ_ALLOC, 16'hA5A5, 21'd5, cfa_pkg::FIT_FIRST);
		send_op(cfa_pkg::REQ_FREE, 16'h0003, '0, cfa_pkg::FIT_FIRST);
		send_op(cfa_pkg::REQ_FREE, 16'hFFFF, '0, cfa_pkg::FIT_FIRST);
		send_op(cfa_pkg::REQ_ALLOC, 16'h0004, 21'd5, cfa_pkg::FIT_BEST);
		send_op(cfa_pkg::REQ_ALLOC, 16'h0005, 21'd50, cfa_pkg::FIT_WORST);
		send_op(cfa_pkg::REQ_FREE, 16'h1234, '0, cfa_pkg::FIT_BEST);
		send_op(cfa_pkg::REQ_STATUS, 16'h0000, '0, cfa_pkg::FIT_FIRST);
		send_op(cfa_pkg::REQ_COMPACT, 16'h0000, '0, cfa_pkg::FIT_FIRST);
		send_op(cfa_pkg::REQ_STATUS, 16'h0000, '0, cfa_pkg::FIT_FIRST);
		// An exact fit of the whole remaining hole leaves no free units.
		send_op(cfa_pkg::REQ_ALLOC, 16'h0006, sh_free, cfa_pkg::FIT_FIRST);
		send_op(cfa_pkg::REQ_COMPACT, 16'h0000, '0, cfa_pkg::FIT_FIRST);
	endtask

	// Fill the table to its limit: the next split must be refused, while an
	// exact fit of the last hole still succeeds.
	task automatic test_table_full();
		write_mem_size(21'd64);
		for (int i = 0; i < MAX_SEGMENTS - 1; i++)
			send_op(cfa_pkg::REQ_ALLOC, 16'(i + 16'h0100), 21'd1, cfa_pkg::fit_t'(i % 4));
		send_op(cfa_pkg::REQ_ALLOC, 16'h0200, 21'd1, cfa_pkg::FIT_FIRST);
		send_op(cfa_pkg::REQ_STATUS, 16'h0000, '0, cfa_pkg::FIT_FIRST);
		send_op(cfa_pkg::REQ_ALLOC, 16'h0201, 21'd33, cfa_pkg::FIT_BEST);
		send_op(cfa_pkg::REQ_COMPACT, 16'h0000, '0, cfa_pkg::FIT_FIRST);
	endtask

	// Out-of-range register values are clamped to 1 and 2^20.
	task automatic test_config_extremes();
		write_mem_size(21'd0);
		send_op(cfa_pkg::REQ_ALLOC, 16'h0007, 21'd1, cfa_pkg::FIT_FIRST);
		send_op(cfa_pkg::REQ_STATUS, 16'h0000, '0, cfa_pkg::FIT_FIRST);
		write_mem_size(21'h1FFFFF);
		send_op(cfa_pkg::REQ_ALLOC, 16'h0008, 21'h100000, cfa_pkg::FIT_WORST);
		send_op(cfa_pkg::REQ_STATUS, 16'h0000, '0, cfa_pkg::FIT_FIRST);
		write_mem_size(21'h100000);
		send_op(cfa_pkg::REQ_STATUS, 16'h0000, '0, cfa_pkg::FIT_FIRST);
	endtask

	// Mostly well-formed traffic: requests and releases from a small owner pool,
	// with some unknown owners, odd sizes, compactions and listings mixed in.
	task automatic test_random_traffic(int count, logic [20:0] mem, int idle, int stall);
		int r;
		logic [SIZE_W-1:0] sz;
		write_mem_size(mem);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < 8; i++) owner_pool[i] = 16'($urandom);
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			if (r < 52) begin
				if ($urandom_range(19) == 0) sz = 21'($urandom);
				else sz = 21'($urandom_range(1, sh_mem / 6 + 1));
				send_op(cfa_pkg::REQ_ALLOC, owner_pool[$urandom_range(7)], sz,
					cfa_pkg::fit_t'($urandom_range(3)));
			end else if (r < 80) begin
				send_op(cfa_pkg::REQ_FREE, owner_pool[$urandom_range(7)], 21'($urandom),
					cfa_pkg::fit_t'($urandom_range(3)));
			end else if (r < 86) begin
				send_op(cfa_pkg::REQ_FREE, 16'($urandom), 21'($urandom),
					cfa_pkg::fit_t'($urandom_range(3)));
			end else if (r < 93) begin
				send_op(cfa_pkg::REQ_COMPACT, 16'($urandom), 21'($urandom),
					cfa_pkg::fit_t'($urandom_range(3)));
			end else begin
				send_op(cfa_pkg::REQ_STATUS, 16'($urandom), 21'($urandom),
					cfa_pkg::fit_t'($urandom_range(3)));
			end
		end
		drain();
	endtask

	// A long receiver hold-off while the sender keeps offering operations; the
	// block must stall its input and lose nothing.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		@(negedge clk);
		hold_cycles = 3000;
		for (int i = 0; i < 12; i++)
			send_op(cfa_pkg::REQ_ALLOC, 16'(16'h0900 + i), 21'($urandom_range(1, 40)),
				cfa_pkg::fit_t'($urandom_range(3)));
		send_op(cfa_pkg::REQ_STATUS, 16'h0000, '0, cfa_pkg::FIT_FIRST);
		drain();
	endtask

	initial begin
		sh_mem = cfa_pkg::SIZE_LIMIT;
		table_reinit();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_state();
		test_directed_ops();
		test_table_full();
		test_config_extremes();
		test_random_traffic(97, 21'd300, 0, 0);
		test_random_traffic(97, 21'd1000, 80, 0);
		test_random_traffic(97, 21'd37, 0, 80);
		test_random_traffic(97, 21'h100000, 21, 21);
		test_backpressure();
		$display("Covered %0d operations, %0d result beats and %0d memory_size writes,",
			ops_sent, beats_seen, configs_done);
		$display("including a full table, clamped sizes and a long output hold-off.");
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d errors", errors);
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#200ms;
		$display("Global timeout reached");
		$display("Simulation FAILED");
		$finish;
	end
endmodule
